// File: sv/pvm_pkg.sv
// Shared types, constants and helpers for the pot smoothing and volume map block.
`timescale 1ns / 1ps

package pvm_pkg;

    localparam int NUM_CH    = 4;
    localparam int Y_W       = 16;  // stored filter output, signed
    localparam int GAIN_W    = 16;  // tone gain, all fraction bits
    localparam int BW        = 17;  // B operand: covers signed 16 and unsigned up to 16
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [CNT_W-1:0] MAC_LAST = 3'd5;
    localparam logic [CNT_W-1:0] MAP_LAST = 3'd4;

    // Coefficient magnitudes with 31 fraction bits
    localparam longint unsigned B0_Q31     = 64'd28688664;
    localparam longint unsigned B1_Q31     = 64'd57377327;
    localparam longint unsigned A1_Q31     = 64'd3537893368;
    localparam longint unsigned A2_MAG_Q31 = 64'd1505164374;

    localparam logic [CFG_IDX_W-1:0] CFG_TREBLE_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASS_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TREBLE_NEGATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_NEGATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASS_NEGATE   = 3'd5;

    localparam logic [GAIN_W-1:0] TREBLE_GAIN_RST = 16'd29491;
    localparam logic [GAIN_W-1:0] MIDDLE_GAIN_RST = 16'd29491;
    localparam logic [GAIN_W-1:0] BASS_GAIN_RST   = 16'd24904;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_FIN,
        ST_MAP,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_B0_X,
        OP_B1_X1,
        OP_B0_X2,
        OP_A1_Y1,
        OP_A2_Y2,
        OP_SQUARE,
        OP_GAIN
    } t_op;

    typedef struct packed {
        logic       mul_en;
        t_op        op;
        logic [1:0] ch;
        logic       acc_load;
        logic       acc_add;
        logic       fin;
        logic       map_cap;
        logic [1:0] cap_ch;
        logic       out_load;
    } t_ctrl;

    // Round a Q31 magnitude to nearest at the given number of fraction bits
    function automatic longint to_coef(input longint unsigned q31, input int frac);
        longint unsigned t;
        t = q31 >> (31 - frac - 1);
        return longint'((t + 64'd1) >> 1);
    endfunction

endpackage

// File: sv/pvm_if.sv
// Handshake interfaces for the knob readings and the mapped levels.
`timescale 1ns / 1ps

interface pvm_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] master_raw;
    logic [SAMPLE_BITS-1:0] treble_raw;
    logic [SAMPLE_BITS-1:0] middle_raw;
    logic [SAMPLE_BITS-1:0] bass_raw;

    modport source (output valid, output master_raw, output treble_raw,
                    output middle_raw, output bass_raw, input ready);
    modport sink   (input valid, input master_raw, input treble_raw,
                    input middle_raw, input bass_raw, output ready);
endinterface

interface pvm_out_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                        valid;
    logic                        ready;
    logic [SAMPLE_BITS-1:0]      master_level;
    logic signed [SAMPLE_BITS:0] treble_level;
    logic signed [SAMPLE_BITS:0] middle_level;
    logic signed [SAMPLE_BITS:0] bass_level;

    modport source (output valid, output master_level, output treble_level,
                    output middle_level, output bass_level, input ready);
    modport sink   (input valid, input master_level, input treble_level,
                    input middle_level, input bass_level, output ready);
endinterface

// File: sv/pot_smoothing_volume_map.sv
// Top level: four biquad-smoothed knob readings mapped to master and tone levels.
`timescale 1ns / 1ps
//
//  channel   dir  handshake          payload
//  i_pot     in   valid / ready      master_raw, treble_raw, middle_raw, bass_raw
//  o_level   out  valid / ready      master_level, treble_level, middle_level, bass_level
//  i_cfg_*   in   i_cfg_we           i_cfg_idx (register), i_cfg_wdata
//
//  One transaction runs four channels in turn (five multiplies on the shared
//  multiplier, one last add, one finalise each), then the mapping products and
//  one load into the output register; the multiplier sets this. A new transaction
//  is taken only once the previous one has been loaded and the sequencer is idle.
//  i_pot.ready is high only while idle; a waiting result does not block acceptance,
//  but a finished transaction holds in place until the output register is free.
//  Reset is synchronous and clears the filter history, configuration, output valid and control.

module pot_smoothing_volume_map
    import pvm_pkg::*;
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pvm_in_if.sink               i_pot,
    pvm_out_if.source            o_level,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int S     = SAMPLE_BITS;
    localparam int AW    = (COEF_FRAC_BITS + 2 > GAIN_W + 1) ? COEF_FRAC_BITS + 2 : GAIN_W + 1;
    localparam int PW    = AW + BW;
    localparam int ACC_W = PW + 3;
    localparam int QW    = ACC_W - COEF_FRAC_BITS;

    localparam logic signed [AW-1:0] C_B0  = AW'(to_coef(B0_Q31, COEF_FRAC_BITS));
    localparam logic signed [AW-1:0] C_B1  = AW'(to_coef(B1_Q31, COEF_FRAC_BITS));
    localparam logic signed [AW-1:0] C_A1  = AW'(to_coef(A1_Q31, COEF_FRAC_BITS));
    localparam logic signed [AW-1:0] C_A2N = AW'(-to_coef(A2_MAG_Q31, COEF_FRAC_BITS));

    localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
    localparam logic signed [QW-1:0] Q_MIN = QW'(-32768);
    localparam logic [S-1:0]         FS    = {S{1'b1}};

    t_ctrl ctrl;
    logic  seq_ready;
    logic  accept;

    logic [S-1:0]            r_x        [0:NUM_CH-1];
    logic [S-1:0]            r_past_in  [0:2*NUM_CH-1];
    logic signed [Y_W-1:0]   r_past_out [0:2*NUM_CH-1];
    logic [S-1:0]            r_lvl      [0:NUM_CH-1];
    logic [GAIN_W-1:0]       r_gain     [1:NUM_CH-1];
    logic                    r_neg      [1:NUM_CH-1];
    logic [S-1:0]            r_res_master;
    logic signed [S:0]       r_res_tone [1:NUM_CH-1];

    logic                    r_out_valid;
    logic [S-1:0]            r_out_master;
    logic signed [S:0]       r_out_tone [1:NUM_CH-1];

    logic signed [AW-1:0]    op_a;
    logic signed [BW-1:0]    op_b;
    logic signed [PW-1:0]    prod;
    logic signed [ACC_W-1:0] acc;

    logic [2:0]              idx0, idx1;
    logic signed [QW-1:0]    q_floor, q_tz;
    logic signed [Y_W-1:0]   y_sat;
    logic signed [Y_W:0]     y_ext;
    logic [S-1:0]            lvl;

    logic [S-1:0]            sq_hi, sq_lo, sq_level;
    logic [S:0]              sq_sum;
    logic [S-1:0]            tone_mag;
    logic signed [S:0]       tone_level;

    assign accept      = i_pot.valid && seq_ready;
    assign i_pot.ready = seq_ready;

    pvm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_free (!r_out_valid || o_level.ready),
        .o_ready    (seq_ready),
        .o_ctrl     (ctrl)
    );

    pvm_mac #(
        .AW    (AW),
        .BW_P  (BW),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_prod (prod),
        .o_acc  (acc)
    );

    // Operand selection for the shared multiplier
    assign idx0 = {ctrl.ch, 1'b0};
    assign idx1 = {ctrl.ch, 1'b1};

    always_comb begin
        case (ctrl.op)
            OP_B0_X, OP_B0_X2: op_a = C_B0;
            OP_B1_X1:          op_a = C_B1;
            OP_A1_Y1:          op_a = C_A1;
            OP_A2_Y2:          op_a = C_A2N;
            OP_SQUARE:         op_a = {{(AW-S){1'b0}}, r_lvl[0]};
            OP_GAIN:           op_a = {{(AW-GAIN_W){1'b0}}, r_gain[ctrl.ch]};
            default:           op_a = '0;
        endcase
        case (ctrl.op)
            OP_B0_X:   op_b = {{(BW-S){1'b0}}, r_x[ctrl.ch]};
            OP_B1_X1:  op_b = {{(BW-S){1'b0}}, r_past_in[idx0]};
            OP_B0_X2:  op_b = {{(BW-S){1'b0}}, r_past_in[idx1]};
            OP_A1_Y1:  op_b = {{(BW-Y_W){r_past_out[idx0][Y_W-1]}}, r_past_out[idx0]};
            OP_A2_Y2:  op_b = {{(BW-Y_W){r_past_out[idx1][Y_W-1]}}, r_past_out[idx1]};
            OP_SQUARE: op_b = {{(BW-S){1'b0}}, r_lvl[0]};
            OP_GAIN:   op_b = {{(BW-S){1'b0}}, r_lvl[ctrl.ch]};
            default:   op_b = '0;
        endcase
    end

    // Finalise: truncate toward zero, saturate to 16 bits, clamp to 0..full scale
    always_comb begin
        q_floor = QW'(acc >>> COEF_FRAC_BITS);
        q_tz    = q_floor;
        if (acc[ACC_W-1] && (acc[COEF_FRAC_BITS-1:0] != '0)) begin
            q_tz = q_floor + QW'(1);
        end
        if (q_tz > Q_MAX) begin
            y_sat = Y_W'(Q_MAX);
        end else if (q_tz < Q_MIN) begin
            y_sat = Y_W'(Q_MIN);
        end else begin
            y_sat = q_tz[Y_W-1:0];
        end
        y_ext = {y_sat[Y_W-1], y_sat};
        if (y_ext <= 0) begin
            lvl = '0;
        end else if (y_ext >= $signed({{(Y_W+1-S){1'b0}}, FS})) begin
            lvl = FS;
        end else begin
            lvl = y_ext[S-1:0];
        end
    end

    // Square law: p / (2^S - 1) = hi + (hi + lo) / (2^S - 1), the latter 0..2
    always_comb begin
        sq_hi  = prod[2*S-1:S];
        sq_lo  = prod[S-1:0];
        sq_sum = {1'b0, sq_hi} + {1'b0, sq_lo};
        if (sq_sum >= {FS, 1'b0}) begin
            sq_level = sq_hi + S'(2);
        end else if (sq_sum >= {1'b0, FS}) begin
            sq_level = sq_hi + S'(1);
        end else begin
            sq_level = sq_hi;
        end
        tone_mag = prod[GAIN_W +: S];
        if (r_neg[ctrl.cap_ch]) begin
            tone_level = -$signed({1'b0, tone_mag});
        end else begin
            tone_level = $signed({1'b0, tone_mag});
        end
    end

    // Filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2 * NUM_CH; i++) begin
                r_past_in[i]  <= '0;
                r_past_out[i] <= '0;
            end
        end else if (ctrl.fin) begin
            r_past_in[idx1]  <= r_past_in[idx0];
            r_past_in[idx0]  <= r_x[ctrl.ch];
            r_past_out[idx1] <= r_past_out[idx0];
            r_past_out[idx0] <= y_sat;
        end
    end

    // Transaction payload and intermediate results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x[0] <= i_pot.master_raw;
            r_x[1] <= i_pot.treble_raw;
            r_x[2] <= i_pot.middle_raw;
            r_x[3] <= i_pot.bass_raw;
        end
        if (ctrl.fin) begin
            r_lvl[ctrl.ch] <= lvl;
        end
        if (ctrl.map_cap) begin
            if (ctrl.cap_ch == 2'd0) begin
                r_res_master <= sq_level;
            end else begin
                r_res_tone[ctrl.cap_ch] <= tone_level;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[1] <= TREBLE_GAIN_RST;
            r_gain[2] <= MIDDLE_GAIN_RST;
            r_gain[3] <= BASS_GAIN_RST;
            r_neg[1]  <= 1'b0;
            r_neg[2]  <= 1'b0;
            r_neg[3]  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TREBLE_GAIN:   r_gain[1] <= i_cfg_wdata;
                CFG_MIDDLE_GAIN:   r_gain[2] <= i_cfg_wdata;
                CFG_BASS_GAIN:     r_gain[3] <= i_cfg_wdata;
                CFG_TREBLE_NEGATE: r_neg[1]  <= i_cfg_wdata[0];
                CFG_MIDDLE_NEGATE: r_neg[2]  <= i_cfg_wdata[0];
                CFG_BASS_NEGATE:   r_neg[3]  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_level.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_master  <= r_res_master;
            r_out_tone[1] <= r_res_tone[1];
            r_out_tone[2] <= r_res_tone[2];
            r_out_tone[3] <= r_res_tone[3];
        end
    end

    assign o_level.valid        = r_out_valid;
    assign o_level.master_level = r_out_master;
    assign o_level.treble_level = r_out_tone[1];
    assign o_level.middle_level = r_out_tone[2];
    assign o_level.bass_level   = r_out_tone[3];

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_pot.ready)
        else $error("input ready straight after a transaction was taken");

    a_fin_mult_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.fin |-> !ctrl.mul_en && !ctrl.acc_add && !ctrl.acc_load)
        else $error("finalise overlaps multiplier activity");

    a_add_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.acc_add |-> $past(ctrl.acc_load || ctrl.acc_add))
        else $error("accumulate without a preceding load");

    a_square_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.map_cap && ctrl.cap_ch == 2'd0) |-> sq_level <= FS)
        else $error("square-law level beyond full scale");

endmodule

// File: sv/pvm_mac.sv
// Shared signed multiplier with registered product and accumulator.
`timescale 1ns / 1ps

module pvm_mac
    import pvm_pkg::*;
#(
    parameter int AW    = 24,
    parameter int BW_P  = 17,
    parameter int ACC_W = 44
) (
    input  logic                          i_clk,
    input  t_ctrl                         i_ctrl,
    input  logic signed [AW-1:0]          i_a,
    input  logic signed [BW_P-1:0]        i_b,
    output logic signed [AW+BW_P-1:0]     o_prod,
    output logic signed [ACC_W-1:0]       o_acc
);

    localparam int PW = AW + BW_P;

    logic signed [PW-1:0]    r_prod;
    logic signed [PW-1:0]    n_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] prod_ext;

    assign n_prod   = i_a * i_b;
    assign prod_ext = {{(ACC_W-PW){r_prod[PW-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_ctrl.acc_load) begin
            r_acc <= prod_ext;
        end else if (i_ctrl.acc_add) begin
            r_acc <= r_acc + prod_ext;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// File: sv/pvm_seq.sv
// Sequencer stepping the shared multiplier through filter and map products.
`timescale 1ns / 1ps

module pvm_seq
    import pvm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_free,
    output logic  o_ready,
    output t_ctrl o_ctrl
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_ch, n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ch    = r_ch;
        o_ctrl  = '0;
        o_ctrl.op = OP_B0_X;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_MAC;
                    n_cnt   = '0;
                    n_ch    = '0;
                end
            end
            ST_MAC: begin
                // product k issued at count k and registered, summed at the next count
                o_ctrl.ch       = r_ch;
                o_ctrl.mul_en   = (r_cnt != MAC_LAST);
                o_ctrl.acc_load = (r_cnt == CNT_W'(1));
                o_ctrl.acc_add  = (r_cnt > CNT_W'(1));
                case (r_cnt)
                    3'd0:    o_ctrl.op = OP_B0_X;
                    3'd1:    o_ctrl.op = OP_B1_X1;
                    3'd2:    o_ctrl.op = OP_B0_X2;
                    3'd3:    o_ctrl.op = OP_A1_Y1;
                    default: o_ctrl.op = OP_A2_Y2;
                endcase
                if (r_cnt == MAC_LAST) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FIN: begin
                o_ctrl.fin = 1'b1;
                o_ctrl.ch  = r_ch;
                n_cnt      = '0;
                if (r_ch == 2'(NUM_CH - 1)) begin
                    n_state = ST_MAP;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = ST_MAC;
                end
            end
            ST_MAP: begin
                o_ctrl.mul_en  = (r_cnt != MAP_LAST);
                o_ctrl.op      = (r_cnt == '0) ? OP_SQUARE : OP_GAIN;
                o_ctrl.ch      = r_cnt[1:0];
                o_ctrl.map_cap = (r_cnt != '0);
                o_ctrl.cap_ch  = r_cnt[1:0] - 2'd1;
                if (r_cnt == MAP_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule
